@@ rtl/hcfd_pkg.sv @@
// hcfd_pkg: shared types, character codes and helpers for the hex command frame decoder
// no dependencies; used by the interfaces and the top level

package hcfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned STORE_N  = 4;
    localparam int unsigned STORE_AW = 2;

    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h3C; // '<'
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h3E; // '>'
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_1     = 8'h31;
    localparam logic [BYTE_W-1:0] CH_2     = 8'h32;
    localparam logic [BYTE_W-1:0] CH_3     = 8'h33;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_F     = 8'h46;

    localparam logic [BYTE_W-1:0] LIMIT_TOP   = 8'd100;
    localparam logic [BYTE_W-1:0] LIMIT_CLAMP = 8'd99;

    localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
    localparam logic [POS_W-1:0] POS_LAST  = 3'd5;

    localparam int unsigned EN_TEMP   = 0;
    localparam int unsigned EN_LIGHT  = 1;
    localparam int unsigned EN_REPORT = 2;

    typedef enum logic [1:0] {
        KIND_ABSORB = 2'd0,
        KIND_PASS   = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_REJECT = 2'd3
    } result_kind_t;

    typedef enum logic [2:0] {
        NOTICE_NONE       = 3'd0,
        NOTICE_TEMP_ON    = 3'd1,
        NOTICE_TEMP_OFF   = 3'd2,
        NOTICE_LIGHT_ON   = 3'd3,
        NOTICE_LIGHT_OFF  = 3'd4,
        NOTICE_REPORT_END = 3'd5
    } notice_t;

    // bit 4 set means not an uppercase hex digit
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [4:0] d;
        begin
            if (c >= CH_0 && c <= CH_9)
            begin
                d = {1'b0, 4'(c - CH_0)};
            end
            else if (c >= CH_A && c <= CH_F)
            begin
                d = {1'b0, 4'(c - CH_A + 8'd10)};
            end
            else
            begin
                d = 5'h10;
            end
            return d;
        end
    endfunction

    function automatic logic [BYTE_W-1:0] clamp_high(input logic [BYTE_W-1:0] v);
        begin
            return (v == LIMIT_TOP) ? LIMIT_CLAMP : v;
        end
    endfunction

endpackage

@@ rtl/hcfd_rx_if.sv @@
// hcfd_rx_if: request channel carrying one received byte
// depends on hcfd_pkg

interface hcfd_rx_if
    import hcfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/hcfd_res_if.sv @@
// hcfd_res_if: request channel carrying one decoder result
// depends on hcfd_pkg

interface hcfd_res_if
    import hcfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        result_kind;
    logic [BYTE_W-1:0] passthrough_byte;
    logic [2:0]        notice;
    logic [BYTE_W-1:0] sample_period;
    logic [BYTE_W-1:0] temp_low_limit;
    logic [BYTE_W-1:0] temp_high_limit;
    logic [BYTE_W-1:0] light_low_limit;
    logic [BYTE_W-1:0] light_high_limit;
    logic              temp_alarm_on;
    logic              light_alarm_on;
    logic              value_report_on;

    modport source (
        output valid, input ready,
        output result_kind, output passthrough_byte, output notice,
        output sample_period, output temp_low_limit, output temp_high_limit,
        output light_low_limit, output light_high_limit,
        output temp_alarm_on, output light_alarm_on, output value_report_on
    );
    modport sink (
        input valid, output ready,
        input result_kind, input passthrough_byte, input notice,
        input sample_period, input temp_low_limit, input temp_high_limit,
        input light_low_limit, input light_high_limit,
        input temp_alarm_on, input light_alarm_on, input value_report_on
    );
endinterface

@@ rtl/hex_command_frame_decoder_unit.sv @@
// hex_command_frame_decoder_unit: top level of the serial command frame decoder
// depends on hcfd_pkg, hcfd_rx_if and hcfd_res_if

// Decodes a received byte stream, one byte per request on rx, one result per
// byte on res. Outside a frame, '<' opens a frame and other bytes come back as
// pass-through; the frame is '<', two command characters, two uppercase hex
// digits and '>'. A good frame is accepted and may update the period, limit
// or enable registers, whose current values ride along with every result.
// Each byte passes through the input register, then the result register; a
// byte can be taken every cycle, the only limit being the result register,
// which holds while res.ready is low.
module hex_command_frame_decoder_unit
    import hcfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hcfd_rx_if.sink   rx,
    hcfd_res_if.source res
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    logic              advance;

    logic              in_frame_reg, in_frame_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] frame_bytes_reg [STORE_N];
    logic              store_en;
    logic [STORE_AW-1:0] store_idx;

    logic [BYTE_W-1:0] period_reg, period_next;
    logic [BYTE_W-1:0] temp_low_reg, temp_low_next;
    logic [BYTE_W-1:0] temp_high_reg, temp_high_next;
    logic [BYTE_W-1:0] light_low_reg, light_low_next;
    logic [BYTE_W-1:0] light_high_reg, light_high_next;
    logic [2:0]        enable_reg, enable_next;

    result_kind_t      kind_reg, kind_next;
    notice_t           notice_reg, notice_next;
    logic [BYTE_W-1:0] pass_reg, pass_next;

    logic [4:0]        hi_dig, lo_dig;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] c1, c2, b;

    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    assign b      = in_byte_reg;
    assign c1     = frame_bytes_reg[0];
    assign c2     = frame_bytes_reg[1];
    assign hi_dig = hex_digit(frame_bytes_reg[2]);
    assign lo_dig = hex_digit(frame_bytes_reg[3]);
    assign value  = {hi_dig[3:0], lo_dig[3:0]};
    assign store_idx = pos_reg[STORE_AW-1:0] - STORE_AW'(1);

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        pos_next        = pos_reg;
        store_en        = 1'b0;
        period_next     = period_reg;
        temp_low_next   = temp_low_reg;
        temp_high_next  = temp_high_reg;
        light_low_next  = light_low_reg;
        light_high_next = light_high_reg;
        enable_next     = enable_reg;
        kind_next       = KIND_ABSORB;
        notice_next     = NOTICE_NONE;
        pass_next       = '0;

        if (!in_frame_reg)
        begin
            if (b == CH_OPEN)
            begin
                in_frame_next = 1'b1;
                pos_next      = POS_FIRST;
            end
            else
            begin
                kind_next = KIND_PASS;
                pass_next = b;
            end
        end
        else if (pos_reg >= POS_LAST || pos_reg == '0)
        begin
            in_frame_next = 1'b0;
            pos_next      = '0;
            if (b != CH_CLOSE || hi_dig[4] || lo_dig[4])
            begin
                kind_next = KIND_REJECT;
            end
            else
            begin
                kind_next = KIND_ACCEPT;
                if (c1 == CH_0 && c2 == CH_1)
                begin
                    period_next = value;
                end
                else if (c1 == CH_1 && c2 == CH_0)
                begin
                    if (value == 8'd0)
                    begin
                        enable_next[EN_TEMP] = 1'b1;
                        notice_next          = NOTICE_TEMP_ON;
                    end
                    else if (value == 8'd1)
                    begin
                        enable_next[EN_TEMP] = 1'b0;
                        notice_next          = NOTICE_TEMP_OFF;
                    end
                end
                else if (c1 == CH_1 && c2 == CH_1)
                begin
                    temp_low_next = value;
                end
                else if (c1 == CH_1 && c2 == CH_2)
                begin
                    temp_high_next = clamp_high(value);
                end
                else if (c1 == CH_2 && c2 == CH_0)
                begin
                    if (value == 8'd0)
                    begin
                        enable_next[EN_LIGHT] = 1'b1;
                        notice_next           = NOTICE_LIGHT_ON;
                    end
                    else if (value == 8'd1)
                    begin
                        enable_next[EN_LIGHT] = 1'b0;
                        notice_next           = NOTICE_LIGHT_OFF;
                    end
                end
                else if (c1 == CH_2 && c2 == CH_1)
                begin
                    light_low_next = value;
                end
                else if (c1 == CH_2 && c2 == CH_2)
                begin
                    light_high_next = clamp_high(value);
                end
                else if (c1 == CH_3 && c2 == CH_0)
                begin
                    if (value == 8'd0)
                    begin
                        enable_next[EN_REPORT] = 1'b1;
                    end
                    else if (value == 8'd1)
                    begin
                        enable_next[EN_REPORT] = 1'b0;
                        notice_next            = NOTICE_REPORT_END;
                    end
                end
            end
        end
        else
        begin
            store_en = 1'b1;
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            in_frame_reg   <= 1'b0;
            pos_reg        <= '0;
            period_reg     <= '0;
            temp_low_reg   <= '0;
            temp_high_reg  <= '0;
            light_low_reg  <= '0;
            light_high_reg <= '0;
            enable_reg     <= '0;
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                in_frame_reg   <= in_frame_next;
                pos_reg        <= pos_next;
                period_reg     <= period_next;
                temp_low_reg   <= temp_low_next;
                temp_high_reg  <= temp_high_next;
                light_low_reg  <= light_low_next;
                light_high_reg <= light_high_next;
                enable_reg     <= enable_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance)
        begin
            kind_reg   <= kind_next;
            notice_reg <= notice_next;
            pass_reg   <= pass_next;
            if (store_en)
            begin
                frame_bytes_reg[store_idx] <= b;
            end
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.result_kind      = kind_reg;
    assign res.passthrough_byte = pass_reg;
    assign res.notice           = notice_reg;
    assign res.sample_period    = period_reg;
    assign res.temp_low_limit   = temp_low_reg;
    assign res.temp_high_limit  = temp_high_reg;
    assign res.light_low_limit  = light_low_reg;
    assign res.light_high_limit = light_high_reg;
    assign res.temp_alarm_on    = enable_reg[EN_TEMP];
    assign res.light_alarm_on   = enable_reg[EN_LIGHT];
    assign res.value_report_on  = enable_reg[EN_REPORT];

endmodule
